### rtl/core/dcg_pkg.sv
`default_nettype none
package dcg_pkg;

  // Register offsets with special handling
  localparam logic [7:0] REG_CTRL      = 8'h00;
  localparam logic [7:0] REG_RESET     = 8'h01;
  localparam logic [7:0] REG_MEM_LO    = 8'h02;
  localparam logic [7:0] REG_MEM_MODE  = 8'h03;
  localparam logic [7:0] REG_CDC_MODE  = 8'h04;
  localparam logic [7:0] REG_CDC_ADDR  = 8'h05;
  localparam logic [7:0] REG_CDC_HOST  = 8'h06;
  localparam logic [7:0] REG_CDC_DATA  = 8'h07;
  localparam logic [7:0] REG_HOST_DATA = 8'h08;
  localparam logic [7:0] REG_HOST_LO   = 8'h09;
  localparam logic [7:0] REG_DMA_HI    = 8'h0a;
  localparam logic [7:0] REG_DMA_LO    = 8'h0b;
  localparam logic [7:0] REG_FLAG_MAIN = 8'h0e;
  localparam logic [7:0] REG_FLAG_SUB  = 8'h0f;
  localparam logic [7:0] REG_CMD_LO    = 8'h10;
  localparam logic [7:0] REG_CMD_HI    = 8'h1f;
  localparam logic [7:0] REG_STAT_LO   = 8'h20;
  localparam logic [7:0] REG_STAT_HI   = 8'h2f;
  localparam logic [7:0] REG_IEN       = 8'h33;
  localparam logic [7:0] REG_HOCK      = 8'h37;
  localparam logic [7:0] REG_CDD_CMD   = 8'h4b;

  // Masks
  localparam logic [7:0] MASK_SUB_HAND  = 8'h1d;
  localparam logic [7:0] MASK_KEEP_MAIN = 8'hc2;
  localparam logic [7:0] MASK_MAIN_VIEW = 8'hc7;
  localparam logic [7:0] MASK_IEN       = 8'h7e;
  localparam logic [7:0] MASK_LOW5      = 8'h1f;
  localparam logic [7:0] MASK_BANK      = 8'hc0;
  localparam logic [7:0] MASK_MODE_MID  = 8'h1c;
  localparam logic [7:0] MASK_LOW3      = 8'h07;
  localparam logic [7:0] MASK_RET_MODE  = 8'h05;
  localparam logic [7:0] MASK_LOW2      = 8'h03;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [15:0] THRESH_RESET  = 16'd64;

  // Side request codes
  localparam logic [2:0] REQ_NONE      = 3'd0;
  localparam logic [2:0] REQ_CDC_READ  = 3'd1;
  localparam logic [2:0] REQ_CDC_WRITE = 3'd2;
  localparam logic [2:0] REQ_CDD_CMD   = 3'd3;
  localparam logic [2:0] REQ_HOST      = 3'd4;

  localparam logic SIDE_MAIN = 1'b0;
  localparam logic SIDE_SUB  = 1'b1;

  typedef struct packed {
    logic       side;
    logic       mode;
    logic [7:0] reg_no;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]  watched;
    logic [15:0] count;
    logic        idle;
    logic [1:0]  shadow;
    logic        doorbell;
    logic        cdd;
    logic [2:0]  bank_mode;
    logic        run;
  } status_t;

  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       clear_pair;
    logic [7:0] read_data;
    logic [2:0] side_request;
  } commit_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] side_request;
    logic       sub_idle_flag;
    logic       cdd_irq_pending;
    logic [1:0] prg_bank_out;
    logic       word_ram_mode;
    logic       sub_run;
    logic       doorbell;
  } result_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_CLR_A = 5'b01000,
    S_CLR_B = 5'b10000
  } state_e;

endpackage
`default_nettype wire

### rtl/core/dcg_if.sv
`default_nettype none
interface dcg_item_if;
  logic       valid;
  logic       ready;
  logic       side;
  logic       mode;
  logic [7:0] reg_index;
  logic [7:0] write_data;
  modport source (output valid, side, mode, reg_index, write_data, input ready);
  modport sink (input valid, side, mode, reg_index, write_data, output ready);
endinterface

interface dcg_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [2:0] side_request;
  logic       sub_idle_flag;
  logic       cdd_irq_pending;
  logic [1:0] prg_bank_out;
  logic       word_ram_mode;
  logic       sub_run;
  logic       doorbell;
  modport source (output valid, read_data, side_request, sub_idle_flag, cdd_irq_pending,
                  prg_bank_out, word_ram_mode, sub_run, doorbell, input ready);
  modport sink (input valid, read_data, side_request, sub_idle_flag, cdd_irq_pending,
                prg_bank_out, word_ram_mode, sub_run, doorbell, output ready);
endinterface

interface dcg_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] poll_threshold;
  modport source (output valid, poll_threshold, input ready);
  modport sink (input valid, poll_threshold, output ready);
endinterface
`default_nettype wire

### rtl/core/dcg_ram.sv
`default_nettype none
module dcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/core/dcg_rules.sv
`default_nettype none
// Access rules: turn one word plus the fetched byte into a store update,
// the new status and the returned byte.
module dcg_rules (
  input  wire dcg_pkg::item_t   item_i,
  input  wire logic [7:0]       old_i,
  input  wire dcg_pkg::status_t stat_i,
  input  wire logic [15:0]      thresh_i,
  output dcg_pkg::status_t      stat_o,
  output dcg_pkg::commit_t      commit_o
);

  logic [7:0]  r;
  logic [7:0]  v;
  logic [7:0]  d0;
  logic [7:0]  d;
  logic [1:0]  shadow_n;
  logic [15:0] count_inc;
  logic        wake;

  always_comb begin
    r         = item_i.reg_no;
    v         = item_i.data;
    stat_o    = stat_i;
    commit_o  = '0;
    wake      = 1'b0;
    d0        = '0;
    d         = '0;
    shadow_n  = stat_i.shadow;
    count_inc = stat_i.count + 16'd1;
    commit_o.side_request = dcg_pkg::REQ_NONE;

    priority if (item_i.side == dcg_pkg::SIDE_SUB && !item_i.mode) begin
      // Track spin polling on one register
      if (r == stat_i.watched) begin
        if (stat_i.count != dcg_pkg::COUNT_MAX) begin
          stat_o.count = count_inc;
          if (count_inc >= thresh_i) begin
            stat_o.idle = 1'b1;
          end
        end
      end else begin
        stat_o.watched = r;
        stat_o.count   = '0;
      end
      priority if (r == dcg_pkg::REG_CTRL) begin
        commit_o.read_data = old_i & dcg_pkg::MASK_LOW2;
      end else if (r == dcg_pkg::REG_RESET) begin
        commit_o.read_data = 8'd1;
      end else if (r == dcg_pkg::REG_MEM_MODE) begin
        commit_o.read_data = old_i & dcg_pkg::MASK_LOW5;
      end else if (r == dcg_pkg::REG_CDC_HOST) begin
        commit_o.read_data = '0;
      end else if (r == dcg_pkg::REG_CDC_DATA) begin
        commit_o.side_request = dcg_pkg::REQ_CDC_READ;
      end else begin
        commit_o.read_data = old_i;
      end
    end else if (item_i.side == dcg_pkg::SIDE_SUB) begin
      priority if (r == dcg_pkg::REG_MEM_LO || r == dcg_pkg::REG_MEM_MODE) begin
        d0 = (v & dcg_pkg::MASK_SUB_HAND) | (old_i & dcg_pkg::MASK_KEEP_MAIN);
        if (d0[0]) begin
          shadow_n = 2'b01;
        end
        if (d0[2]) begin
          d = (((d0 ^ old_i) & dcg_pkg::MASK_RET_MODE) != '0) ? (d0 & ~8'h02) : d0;
        end else begin
          d = (d0 & ~dcg_pkg::MASK_LOW2) | {6'd0, shadow_n};
        end
        stat_o.shadow       = shadow_n;
        stat_o.bank_mode[2] = d[2];
        commit_o.we    = 1'b1;
        commit_o.waddr = dcg_pkg::REG_MEM_MODE;
        commit_o.wdata = d;
        wake = 1'b1;
      end else if (r == dcg_pkg::REG_FLAG_MAIN || r == dcg_pkg::REG_FLAG_SUB) begin
        commit_o.we    = 1'b1;
        commit_o.waddr = dcg_pkg::REG_FLAG_SUB;
        commit_o.wdata = v;
      end else if (r >= dcg_pkg::REG_CMD_LO && r <= dcg_pkg::REG_CMD_HI) begin
        commit_o.we = 1'b0;
      end else if (r == dcg_pkg::REG_CDC_MODE) begin
        commit_o.we         = 1'b1;
        commit_o.waddr      = r;
        commit_o.wdata      = v & dcg_pkg::MASK_LOW3;
        commit_o.clear_pair = 1'b1;
      end else if (r == dcg_pkg::REG_CDC_ADDR) begin
        commit_o.we    = 1'b1;
        commit_o.waddr = r;
        commit_o.wdata = v & dcg_pkg::MASK_LOW5;
      end else if (r == dcg_pkg::REG_CDC_DATA) begin
        commit_o.side_request = dcg_pkg::REQ_CDC_WRITE;
      end else if (r == dcg_pkg::REG_IEN) begin
        commit_o.we    = 1'b1;
        commit_o.waddr = r;
        commit_o.wdata = v & dcg_pkg::MASK_IEN;
        if (v[4] && old_i[2]) begin
          stat_o.cdd = 1'b1;
        end
        wake = 1'b1;
      end else if (r == dcg_pkg::REG_HOCK) begin
        commit_o.we    = 1'b1;
        commit_o.waddr = r;
        commit_o.wdata = v & dcg_pkg::MASK_LOW3;
        if (v[2] && old_i[4]) begin
          stat_o.cdd = 1'b1;
        end
        wake = 1'b1;
      end else if (r == dcg_pkg::REG_CDD_CMD) begin
        commit_o.we    = 1'b1;
        commit_o.waddr = r;
        commit_o.wdata = '0;
        commit_o.side_request = dcg_pkg::REQ_CDD_CMD;
      end else begin
        commit_o.we    = 1'b1;
        commit_o.waddr = r;
        commit_o.wdata = v;
      end
    end else if (!item_i.mode) begin
      priority if (r == dcg_pkg::REG_CTRL) begin
        commit_o.read_data = {7'd0, stat_i.doorbell};
      end else if (r == dcg_pkg::REG_MEM_MODE) begin
        commit_o.read_data = old_i & dcg_pkg::MASK_MAIN_VIEW;
      end else if (r == dcg_pkg::REG_CDC_ADDR) begin
        commit_o.read_data = '0;
      end else begin
        commit_o.read_data = old_i;
      end
    end else begin
      priority if (r == dcg_pkg::REG_CTRL) begin
        stat_o.doorbell = v[0];
        wake = 1'b1;
      end else if (r == dcg_pkg::REG_MEM_MODE) begin
        if (v[1]) begin
          shadow_n = 2'b10;
        end
        if (old_i[2]) begin
          d = ((v ^ 8'h02) & dcg_pkg::MASK_KEEP_MAIN) | (old_i & dcg_pkg::MASK_LOW5);
        end else begin
          d = (v & dcg_pkg::MASK_BANK) | (old_i & dcg_pkg::MASK_MODE_MID)
              | {6'd0, shadow_n};
        end
        stat_o.shadow    = shadow_n;
        stat_o.bank_mode = {d[2], d[7:6]};
        commit_o.we    = 1'b1;
        commit_o.waddr = r;
        commit_o.wdata = d;
        wake = 1'b1;
      end else if (r == dcg_pkg::REG_HOST_DATA) begin
        commit_o.side_request = dcg_pkg::REQ_HOST;
      end else if (r == dcg_pkg::REG_HOST_LO) begin
        commit_o.we = 1'b0;
      end else if (r == dcg_pkg::REG_FLAG_MAIN || r == dcg_pkg::REG_FLAG_SUB) begin
        if (old_i != v) begin
          commit_o.we    = 1'b1;
          commit_o.waddr = dcg_pkg::REG_FLAG_MAIN;
          commit_o.wdata = v;
          wake = 1'b1;
        end
      end else if (r >= dcg_pkg::REG_STAT_LO && r <= dcg_pkg::REG_STAT_HI) begin
        commit_o.we = 1'b0;
      end else begin
        commit_o.we    = 1'b1;
        commit_o.waddr = r;
        commit_o.wdata = v;
        wake = 1'b1;
        if (r == dcg_pkg::REG_RESET) begin
          stat_o.run = v[0] & ~v[1];
        end
      end
    end

    if (wake) begin
      stat_o.idle  = 1'b0;
      stat_o.count = '0;
    end
  end

endmodule
`default_nettype wire

### rtl/core/dual_cpu_gate_array_registers.sv
`default_nettype none
// Byte register file shared by a main and a sub processor. Each input word is
// one byte read or write from one side; each yields exactly one result word
// carrying the returned byte, a side request code and the status bits as they
// stand after the access. The register bytes live in one synchronous RAM of
// REG_COUNT entries; an access fetches the byte it needs (the target, the
// memory mode register, the main flag register or the IEN/HOCK partner), then
// applies the ownership rules and writes back. An item is fetched, then
// modified and written back before the next item is taken; a sub write to
// the CDC mode register also clears the two DMA length bytes with two more
// writes through the single write port. A waiting result holds the block
// only when the next result is ready to leave. After reset a clearing pass
// zeroes the RAM one entry per cycle, during which no item is taken;
// threshold writes are taken at any time (the block is assumed idle when they come).
module dual_cpu_gate_array_registers #(
  parameter int REG_COUNT = 256
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dcg_item_if.sink    item_i,
  dcg_result_if.source result_o,
  dcg_cfg_if.sink     cfg_i
);

  localparam int AW = $clog2(REG_COUNT);
  localparam logic [9:0] RegCountW = 10'(REG_COUNT);
  localparam logic [AW-1:0] LastAddr = AW'(REG_COUNT - 1);

  dcg_pkg::state_e  state_q, state_d;
  dcg_pkg::item_t   item_q;
  dcg_pkg::status_t stat_q, stat_n;
  dcg_pkg::commit_t commit;
  dcg_pkg::result_t result_q;
  logic [15:0]      thresh_q;
  logic [AW-1:0]    clr_q;
  logic             out_valid_q;

  logic             accept;
  logic             load;
  logic [9:0]       idx_ext;
  logic [7:0]       r_mod;
  logic [7:0]       fetch_addr;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  // Wrap the offset into the store
  always_comb begin
    idx_ext = {2'b00, item_i.reg_index};
    r_mod   = (idx_ext >= RegCountW) ? 8'(idx_ext - RegCountW) : item_i.reg_index;
  end

  // Pick the byte each access needs to see
  always_comb begin
    fetch_addr = r_mod;
    if (item_i.mode) begin
      if (item_i.side == dcg_pkg::SIDE_SUB) begin
        priority if (r_mod == dcg_pkg::REG_MEM_LO || r_mod == dcg_pkg::REG_MEM_MODE) begin
          fetch_addr = dcg_pkg::REG_MEM_MODE;
        end else if (r_mod == dcg_pkg::REG_IEN) begin
          fetch_addr = dcg_pkg::REG_HOCK;
        end else if (r_mod == dcg_pkg::REG_HOCK) begin
          fetch_addr = dcg_pkg::REG_IEN;
        end else begin
          fetch_addr = r_mod;
        end
      end else begin
        priority if (r_mod == dcg_pkg::REG_FLAG_MAIN || r_mod == dcg_pkg::REG_FLAG_SUB) begin
          fetch_addr = dcg_pkg::REG_FLAG_MAIN;
        end else begin
          fetch_addr = r_mod;
        end
      end
    end
  end

  assign item_i.ready = (state_q == dcg_pkg::S_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign load         = (state_q == dcg_pkg::S_LOOK) && (!out_valid_q || result_o.ready);

  dcg_rules u_rules (
    .item_i   (item_q),
    .old_i    (ram_rdata),
    .stat_i   (stat_q),
    .thresh_i (thresh_q),
    .stat_o   (stat_n),
    .commit_o (commit)
  );

  // Write port: clearing pass, commit of an access, then the DMA length pair
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    unique case (state_q)
      dcg_pkg::S_CLEAR: begin
        ram_we = 1'b1;
      end
      dcg_pkg::S_LOOK: begin
        ram_we    = load && commit.we;
        ram_waddr = AW'(commit.waddr);
        ram_wdata = commit.wdata;
      end
      dcg_pkg::S_CLR_A: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(dcg_pkg::REG_DMA_HI);
      end
      dcg_pkg::S_CLR_B: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(dcg_pkg::REG_DMA_LO);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  dcg_ram #(
    .WIDTH (8),
    .DEPTH (REG_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (AW'(fetch_addr)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dcg_pkg::S_CLEAR: begin
        if (clr_q == LastAddr) begin
          state_d = dcg_pkg::S_IDLE;
        end
      end
      dcg_pkg::S_IDLE: begin
        if (accept) begin
          state_d = dcg_pkg::S_LOOK;
        end
      end
      dcg_pkg::S_LOOK: begin
        if (load) begin
          state_d = commit.clear_pair ? dcg_pkg::S_CLR_A : dcg_pkg::S_IDLE;
        end
      end
      dcg_pkg::S_CLR_A: begin
        state_d = dcg_pkg::S_CLR_B;
      end
      dcg_pkg::S_CLR_B: begin
        state_d = dcg_pkg::S_IDLE;
      end
      default: begin
        state_d = dcg_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcg_pkg::S_CLEAR;
      clr_q       <= '0;
      stat_q      <= '0;
      thresh_q    <= dcg_pkg::THRESH_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == dcg_pkg::S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cfg_i.valid) begin
        thresh_q <= cfg_i.poll_threshold;
      end
      // Advance status only when the result is committed
      if (load) begin
        stat_q      <= stat_n;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold the word in flight and the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.side   <= item_i.side;
      item_q.mode   <= item_i.mode;
      item_q.reg_no <= r_mod;
      item_q.data   <= item_i.write_data;
    end
    if (load) begin
      result_q.read_data       <= commit.read_data;
      result_q.side_request    <= commit.side_request;
      result_q.sub_idle_flag   <= stat_n.idle;
      result_q.cdd_irq_pending <= stat_n.cdd;
      result_q.prg_bank_out    <= stat_n.bank_mode[1:0];
      result_q.word_ram_mode   <= stat_n.bank_mode[2];
      result_q.sub_run         <= stat_n.run;
      result_q.doorbell        <= stat_n.doorbell;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.read_data       = result_q.read_data;
  assign result_o.side_request    = result_q.side_request;
  assign result_o.sub_idle_flag   = result_q.sub_idle_flag;
  assign result_o.cdd_irq_pending = result_q.cdd_irq_pending;
  assign result_o.prg_bank_out    = result_q.prg_bank_out;
  assign result_o.word_ram_mode   = result_q.word_ram_mode;
  assign result_o.sub_run         = result_q.sub_run;
  assign result_o.doorbell        = result_q.doorbell;

endmodule
`default_nettype wire

### tb/tb_dual_cpu_gate_array_registers.sv
`timescale 1ns / 1ps

module tb_dual_cpu_gate_array_registers;
  import dcg_pkg::*;

  // Access kinds carried by the mode field of an input word.
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // Quiet cycles tolerated before the run is declared hung. This covers the
  // clearing pass after reset (one byte per cycle), the long receiver hold
  // and the longest idle bursts on both sides, with a wide margin.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 150;

  logic clk_i = 1'b0;
  logic rst_ni;

  dcg_item_if   item_if ();
  dcg_result_if result_if ();
  dcg_cfg_if    cfg_if ();

  dual_cpu_gate_array_registers uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the shared register file and the mailbox status.
  logic [7:0]  mirror_bytes [0:255];
  logic [7:0]  mirror_watched;
  logic [15:0] mirror_count;
  logic        mirror_idle;
  logic [1:0]  mirror_handover;   // bit0 RET, bit1 DMNA
  logic        mirror_doorbell;
  logic        mirror_cdd;
  logic [2:0]  mirror_bank_mode;  // bits 1:0 bank, bit 2 word RAM mode
  logic        mirror_run;
  logic [15:0] poll_limit;

  item_t       pending_accesses [$];
  result_t     predicted_replies [$];
  item_t       cur_access;
  result_t     want;

  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_trig = 0;
  int unsigned hold_seen = 0;
  logic        idling_on = 1'b1;

  // Any write that counts as activity on the shared side ends a spin.
  function automatic void wake_sub();
    mirror_idle  = 1'b0;
    mirror_count = '0;
  endfunction

  // Apply one access to the mirror and return the word it must produce.
  function automatic result_t predict_access(input item_t acc);
    result_t    res;
    logic [7:0] r;
    logic [7:0] v;
    logic [7:0] prev;
    logic [7:0] d;
    res = '0;
    r = acc.reg_no;
    v = acc.data;
    if (acc.side == SIDE_SUB && acc.mode == ACC_READ) begin
      // Track spin reads before looking up the byte.
      if (r == mirror_watched) begin
        if (mirror_count != COUNT_MAX) begin
          mirror_count = mirror_count + 16'd1;
          if (mirror_count >= poll_limit) mirror_idle = 1'b1;
        end
      end else begin
        mirror_watched = r;
        mirror_count   = '0;
      end
      case (r)
        REG_CTRL:     res.read_data = mirror_bytes[REG_CTRL] & MASK_LOW2;
        REG_RESET:    res.read_data = 8'h01;
        REG_MEM_MODE: res.read_data = mirror_bytes[REG_MEM_MODE] & MASK_LOW5;
        REG_CDC_HOST: res.read_data = 8'h00;
        REG_CDC_DATA: res.side_request = REQ_CDC_READ;
        default:      res.read_data = mirror_bytes[r];
      endcase
    end else if (acc.side == SIDE_SUB) begin
      if (r == REG_MEM_LO || r == REG_MEM_MODE) begin
        // Sub half of the RET/DMNA handover.
        prev = mirror_bytes[REG_MEM_MODE];
        d = (v & MASK_SUB_HAND) | (prev & MASK_KEEP_MAIN);
        if (d[0]) mirror_handover = 2'b01;
        if (d[2]) begin
          if (((d ^ prev) & MASK_RET_MODE) != 8'h00) d[1] = 1'b0;
        end else begin
          d = {d[7:2], mirror_handover};
        end
        mirror_bytes[REG_MEM_MODE] = d;
        mirror_bank_mode[2] = d[2];
        wake_sub();
      end else if (r == REG_FLAG_MAIN || r == REG_FLAG_SUB) begin
        mirror_bytes[REG_FLAG_SUB] = v;
      end else if (r >= REG_CMD_LO && r <= REG_CMD_HI) begin
        // main-owned command words: drop
      end else begin
        case (r)
          REG_CDC_MODE: begin
            mirror_bytes[REG_CDC_MODE] = v & MASK_LOW3;
            mirror_bytes[REG_DMA_HI] = 8'h00;
            mirror_bytes[REG_DMA_LO] = 8'h00;
          end
          REG_CDC_ADDR: mirror_bytes[REG_CDC_ADDR] = v & MASK_LOW5;
          REG_CDC_DATA: res.side_request = REQ_CDC_WRITE;
          REG_IEN: begin
            mirror_bytes[REG_IEN] = v & MASK_IEN;
            if (v[4] && mirror_bytes[REG_HOCK][2]) mirror_cdd = 1'b1;
            wake_sub();
          end
          REG_HOCK: begin
            mirror_bytes[REG_HOCK] = v & MASK_LOW3;
            if (v[2] && mirror_bytes[REG_IEN][4]) mirror_cdd = 1'b1;
            wake_sub();
          end
          REG_CDD_CMD: begin
            mirror_bytes[REG_CDD_CMD] = 8'h00;
            res.side_request = REQ_CDD_CMD;
          end
          default: mirror_bytes[r] = v;
        endcase
      end
    end else if (acc.mode == ACC_READ) begin
      case (r)
        REG_CTRL:     res.read_data = {7'b0, mirror_doorbell};
        REG_MEM_MODE: res.read_data = mirror_bytes[REG_MEM_MODE] & MASK_MAIN_VIEW;
        REG_CDC_ADDR: res.read_data = 8'h00;
        default:      res.read_data = mirror_bytes[r];
      endcase
    end else begin
      if (r == REG_CTRL) begin
        mirror_doorbell = v[0];
        wake_sub();
      end else if (r == REG_MEM_MODE) begin
        // Main half of the handover; bank and mode follow the new byte.
        prev = mirror_bytes[REG_MEM_MODE];
        d = v;
        if (d[1]) mirror_handover = 2'b10;
        if (prev[2]) begin
          d[1] = ~d[1];
          d = (d & MASK_KEEP_MAIN) | (prev & MASK_LOW5);
        end else begin
          d = (d & MASK_BANK) | (prev & MASK_MODE_MID) | {6'b0, mirror_handover};
        end
        mirror_bytes[REG_MEM_MODE] = d;
        mirror_bank_mode = {d[2], d[7:6]};
        wake_sub();
      end else if (r == REG_HOST_DATA) begin
        res.side_request = REQ_HOST;
      end else if (r == REG_HOST_LO) begin
        // read-only from main: drop
      end else if (r == REG_FLAG_MAIN || r == REG_FLAG_SUB) begin
        if (mirror_bytes[REG_FLAG_MAIN] != v) begin
          mirror_bytes[REG_FLAG_MAIN] = v;
          wake_sub();
        end
      end else if (r >= REG_STAT_LO && r <= REG_STAT_HI) begin
        // sub-owned status words: drop
      end else begin
        mirror_bytes[r] = v;
        wake_sub();
        if (r == REG_RESET) mirror_run = v[0] & ~v[1];
      end
    end
    res.sub_idle_flag   = mirror_idle;
    res.cdd_irq_pending = mirror_cdd;
    res.prg_bank_out    = mirror_bank_mode[1:0];
    res.word_ram_mode   = mirror_bank_mode[2];
    res.sub_run         = mirror_run;
    res.doorbell        = mirror_doorbell;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  function automatic void queue_access(input logic side, input logic acc_mode,
                                       input logic [7:0] r, input logic [7:0] d);
    item_t a;
    a.side   = side;
    a.mode   = acc_mode;
    a.reg_no = r;
    a.data   = d;
    pending_accesses.push_back(a);
  endfunction

  // Registers with their own rules, plus a few plain ones around them.
  function automatic logic [7:0] hot_reg(input int unsigned k);
    case (k)
      0:       return REG_CTRL;
      1:       return REG_RESET;
      2:       return REG_MEM_LO;
      3:       return REG_MEM_MODE;
      4:       return REG_CDC_MODE;
      5:       return REG_CDC_ADDR;
      6:       return REG_CDC_HOST;
      7:       return REG_CDC_DATA;
      8:       return REG_HOST_DATA;
      9:       return REG_HOST_LO;
      10:      return REG_DMA_HI;
      11:      return REG_DMA_LO;
      12:      return REG_FLAG_MAIN;
      13:      return REG_FLAG_SUB;
      14:      return REG_CMD_LO;
      15:      return REG_CMD_HI;
      16:      return REG_STAT_LO;
      17:      return REG_STAT_HI;
      18:      return REG_IEN;
      19:      return REG_HOCK;
      20:      return REG_CDD_CMD;
      21:      return 8'h15;
      22:      return 8'h28;
      default: return 8'hff;
    endcase
  endfunction

  // Fill the pending queue with roughly count words: mostly spin loops,
  // handovers, interrupt enables and flag exchanges, the rest loose accesses.
  task automatic queue_random(input int unsigned count);
    int unsigned made;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  r;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1: begin
          r = hot_reg($urandom_range(0, 23));
          len = $urandom_range(1, (poll_limit < 36) ? poll_limit + 4 : 40);
          repeat (len) queue_access(SIDE_SUB, ACC_READ, r, 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1)) queue_access(SIDE_MAIN, ACC_WRITE,
                                                 hot_reg($urandom_range(0, 23)),
                                                 8'($urandom_range(0, 255)));
          made += len + 1;
        end
        2: begin
          queue_access(SIDE_MAIN, ACC_WRITE, REG_MEM_MODE, 8'($urandom_range(0, 255)));
          queue_access(SIDE_SUB, ACC_WRITE,
                       $urandom_range(0, 1) ? REG_MEM_MODE : REG_MEM_LO,
                       8'($urandom_range(0, 255)));
          queue_access(SIDE_MAIN, ACC_READ, REG_MEM_MODE, 8'($urandom_range(0, 255)));
          queue_access(SIDE_SUB, ACC_READ, REG_MEM_MODE, 8'($urandom_range(0, 255)));
          made += 4;
        end
        3: begin
          queue_access(SIDE_SUB, ACC_WRITE, REG_HOCK, 8'($urandom_range(0, 255)));
          queue_access(SIDE_SUB, ACC_WRITE, REG_IEN, 8'($urandom_range(0, 255)));
          made += 2;
        end
        4: begin
          r = 8'($urandom_range(0, 255));
          queue_access(SIDE_MAIN, ACC_WRITE,
                       $urandom_range(0, 1) ? REG_FLAG_MAIN : REG_FLAG_SUB, r);
          queue_access(SIDE_MAIN, ACC_WRITE, REG_FLAG_MAIN,
                       $urandom_range(0, 1) ? r : 8'($urandom_range(0, 255)));
          queue_access(SIDE_SUB, ACC_READ, REG_FLAG_MAIN, 8'($urandom_range(0, 255)));
          queue_access(SIDE_SUB, ACC_WRITE,
                       $urandom_range(0, 1) ? REG_FLAG_MAIN : REG_FLAG_SUB,
                       8'($urandom_range(0, 255)));
          queue_access(SIDE_MAIN, ACC_READ, REG_FLAG_SUB, 8'($urandom_range(0, 255)));
          made += 5;
        end
        default: begin
          r = ($urandom_range(0, 4) < 2) ? 8'($urandom_range(0, 255))
                                         : hot_reg($urandom_range(0, 23));
          queue_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r,
                       8'($urandom_range(0, 255)));
          made += 1;
        end
      endcase
    end
  endtask

  // Wait until the block has nothing in flight, then let it settle.
  // Look at the queues between edges, once the driver's updates have landed.
  task automatic drain();
    while (pending_accesses.size() != 0 || item_if.valid || predicted_replies.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    @(posedge clk_i);
    cfg_if.valid          <= 1'b1;
    cfg_if.poll_threshold <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    poll_limit = value;
    cfg_if.valid <= 1'b0;
  endtask

  // Driver: present the next pending word, hold it until taken, and
  // predict its reply at the edge where it is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        predicted_replies.push_back(predict_access(cur_access));
      end
      if (!item_if.valid || item_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          item_if.valid <= 1'b0;
        end else if (pending_accesses.size() != 0) begin
          if (idling_on && $urandom_range(0, 5) == 0) begin
            // idle burst before the next word
            send_gap = $urandom_range(0, 10);
            item_if.valid <= 1'b0;
          end else begin
            cur_access = pending_accesses.pop_front();
            item_if.valid      <= 1'b1;
            item_if.side       <= cur_access.side;
            item_if.mode       <= cur_access.mode;
            item_if.reg_index  <= cur_access.reg_no;
            item_if.write_data <= cur_access.data;
          end
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest prediction and
  // drive ready with random stalls and the occasional long hold.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (predicted_replies.size() == 0) begin
          $error("result word with no prediction waiting");
          mismatches++;
        end else begin
          want = predicted_replies.pop_front();
          check_field("read_data", want.read_data, result_if.read_data);
          check_field("side_request", 8'(want.side_request), 8'(result_if.side_request));
          check_field("sub_idle_flag", 8'(want.sub_idle_flag), 8'(result_if.sub_idle_flag));
          check_field("cdd_irq_pending", 8'(want.cdd_irq_pending),
                      8'(result_if.cdd_irq_pending));
          check_field("prg_bank_out", 8'(want.prg_bank_out), 8'(result_if.prg_bank_out));
          check_field("word_ram_mode", 8'(want.word_ram_mode), 8'(result_if.word_ram_mode));
          check_field("sub_run", 8'(want.sub_run), 8'(result_if.sub_run));
          check_field("doorbell", 8'(want.doorbell), 8'(result_if.doorbell));
        end
      end
      if (hold_trig != hold_seen) begin
        hold_seen = hold_trig;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 10);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // Known values on every input from time zero; mirror starts at reset state.
    rst_ni = 1'b0;
    item_if.valid = 1'b0;
    item_if.side = SIDE_MAIN;
    item_if.mode = ACC_READ;
    item_if.reg_index = 8'h00;
    item_if.write_data = 8'h00;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.poll_threshold = THRESH_RESET;
    for (int i = 0; i < 256; i++) mirror_bytes[i] = 8'h00;
    mirror_watched = '0;
    mirror_count = '0;
    mirror_idle = 1'b0;
    mirror_handover = '0;
    mirror_doorbell = 1'b0;
    mirror_cdd = 1'b0;
    mirror_bank_mode = '0;
    mirror_run = 1'b0;
    poll_limit = THRESH_RESET;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass with a threshold of 1: a run of accesses through the register rules.
    write_threshold(16'd1);
    queue_access(SIDE_SUB, ACC_READ, REG_CTRL, 8'h00);       // spin on reg 0 from reset
    queue_access(SIDE_MAIN, ACC_WRITE, REG_CTRL, 8'hff);     // ring the doorbell, wake
    queue_access(SIDE_MAIN, ACC_READ, REG_CTRL, 8'h00);
    queue_access(SIDE_MAIN, ACC_WRITE, REG_RESET, 8'h01);    // release the sub
    queue_access(SIDE_SUB, ACC_READ, REG_RESET, 8'hff);
    queue_access(SIDE_MAIN, ACC_WRITE, REG_MEM_MODE, 8'hc2); // bank bits, DMNA
    queue_access(SIDE_SUB, ACC_WRITE, REG_MEM_MODE, 8'h05);  // RET with one-megabit mode
    queue_access(SIDE_MAIN, ACC_WRITE, REG_MEM_MODE, 8'hff); // mode-set path
    queue_access(SIDE_SUB, ACC_WRITE, REG_MEM_LO, 8'h00);
    queue_access(SIDE_MAIN, ACC_READ, REG_MEM_MODE, 8'h00);
    queue_access(SIDE_SUB, ACC_READ, REG_MEM_MODE, 8'h00);
    queue_access(SIDE_MAIN, ACC_WRITE, REG_DMA_HI, 8'haa);
    queue_access(SIDE_SUB, ACC_WRITE, REG_CDC_MODE, 8'hff);  // clears the DMA length
    queue_access(SIDE_MAIN, ACC_READ, REG_DMA_HI, 8'h00);
    queue_access(SIDE_SUB, ACC_WRITE, REG_CDC_DATA, 8'h3c);
    queue_access(SIDE_SUB, ACC_READ, REG_CDC_DATA, 8'h00);
    queue_access(SIDE_MAIN, ACC_WRITE, REG_HOST_DATA, 8'h55);
    queue_access(SIDE_SUB, ACC_WRITE, REG_CDD_CMD, 8'hff);
    queue_access(SIDE_SUB, ACC_WRITE, REG_HOCK, 8'hff);
    queue_access(SIDE_SUB, ACC_WRITE, REG_IEN, 8'hff);       // pending interrupt, sticky
    queue_access(SIDE_MAIN, ACC_WRITE, REG_FLAG_SUB, 8'h5a);
    queue_access(SIDE_SUB, ACC_WRITE, REG_FLAG_MAIN, 8'ha5);
    queue_access(SIDE_SUB, ACC_READ, REG_STAT_LO, 8'h00);
    queue_access(SIDE_SUB, ACC_READ, REG_STAT_LO, 8'h00);    // idle on second read
    queue_access(SIDE_MAIN, ACC_WRITE, REG_STAT_HI, 8'hff);  // dropped, idle stays
    queue_access(SIDE_SUB, ACC_WRITE, REG_CMD_HI, 8'hff);
    queue_access(SIDE_MAIN, ACC_READ, REG_CDC_ADDR, 8'h00);
    drain();

    // Highest threshold; hold the receiver long enough to back up the input.
    write_threshold(16'hffff);
    queue_random(100);
    hold_trig++;
    drain();

    // Small thresholds so spin loops reach idle; pause mid-way until empty.
    write_threshold(16'($urandom_range(2, 8)));
    queue_random(200);
    drain();
    idling_on = 1'b0;
    queue_random(200);
    drain();

    idling_on = 1'b1;
    write_threshold(16'($urandom_range(9, 40)));
    queue_random(200);
    drain();

    // Last stretch back to back, no idling on either side.
    idling_on = 1'b0;
    write_threshold(16'd3);
    queue_random(250);
    drain();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
